### hw/rtl/iepf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iepf_pkg
// shared types, codes and constants of the ipv4 egress prefix filter
// ----------------------------------------------------------------------------
package iepf_pkg;

   // request kinds on the input channel
   typedef enum logic {
      REQ_FRAME = 1'b0,
      REQ_RULE  = 1'b1
   } req_kind_type;

   // verdict causes
   typedef enum logic [2:0] {
      CAUSE_SHORT_ETH  = 3'd0,
      CAUSE_NOT_IPV4   = 3'd1,
      CAUSE_SHORT_IP   = 3'd2,
      CAUSE_RULE_ALLOW = 3'd3,
      CAUSE_LOOPBACK   = 3'd4,
      CAUSE_NO_ALLOW   = 3'd5
   } cause_type;

   // commands from the parser to the search engine
   typedef enum logic [1:0] {
      CMD_RULE    = 2'd0,
      CMD_VERDICT = 2'd1,
      CMD_SEARCH  = 2'd2
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_SCAN  = 3'd2,
      ST_DRAIN = 3'd3,
      ST_EMIT  = 3'd4
   } bk_state_type;

   localparam int IDX_WIDE_W = 17;

   localparam logic [5:0]  ETH_HDR_BYTES  = 6'd14;
   localparam logic [5:0]  IP_END_BYTES   = 6'd34;
   localparam logic [5:0]  POS_ETYPE_HI   = 6'd12;
   localparam logic [5:0]  POS_ETYPE_LO   = 6'd13;
   localparam logic [5:0]  POS_DEST_FIRST = 6'd30;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [31:0] LOOP_MASK      = 32'hFF00_0000;
   localparam logic [31:0] LOOP_NET       = 32'h7F00_0000;
   localparam logic [5:0]  MAX_PREFIX     = 6'd32;
   localparam logic [7:0]  ALLOW_VALUE    = 8'd1;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   typedef struct packed {
      cmd_kind_type kind;
      cause_type    cause;
      logic [31:0]  address;   // rule address or frame destination
      logic [9:0]   index;
      logic         valid;
      logic [5:0]   plen;
      logic         allow;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [5:0]  plen;
      logic [31:0] address;
      logic        allow;
   } rule_entry_type;

   typedef struct packed {
      logic        verdict;
      cause_type   cause;
      logic [31:0] dest;
   } result_type;

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = 32'd0;
      end else begin
         m = 32'hFFFF_FFFF << (MAX_PREFIX - len);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/iepf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iepf_fifo
// small register queue, first word shown while not empty
// ----------------------------------------------------------------------------
module iepf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] fifo_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = fifo_mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/iepf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iepf_parser
// frame header parser and classifier, turns items into commands
// ----------------------------------------------------------------------------
module iepf_parser
   import iepf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_frame_last,
   input  wire logic [9:0]  req_rule_index,
   input  wire logic        req_rule_valid,
   input  wire logic [5:0]  req_rule_prefix_len,
   input  wire logic [31:0] req_rule_address,
   input  wire logic [7:0]  req_rule_value,
   output logic             cmd_valid,
   output cmd_type          cmd
);

   logic [5:0]  byte_count_ff, byte_count_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [31:0] dest_ff, dest_in;
   logic [5:0]  count_upd;
   logic [15:0] ether_upd;
   logic [31:0] dest_upd;
   logic [IDX_WIDE_W-1:0] idx_wide;
   logic        rule_ok;

   assign idx_wide = IDX_WIDE_W'(req_rule_index);
   assign rule_ok  = (idx_wide < IDX_WIDE_W'(TABLE_ENTRIES)) &&
                     (req_rule_prefix_len <= MAX_PREFIX);

   // header capture for the byte at hand
   always_comb begin
      count_upd = byte_count_ff;
      ether_upd = ether_type_ff;
      dest_upd  = dest_ff;
      if (byte_count_ff < IP_END_BYTES) begin
         if (byte_count_ff == POS_ETYPE_HI || byte_count_ff == POS_ETYPE_LO) begin
            ether_upd = {ether_type_ff[7:0], req_frame_byte};
         end else if (byte_count_ff >= POS_DEST_FIRST) begin
            dest_upd = {dest_ff[23:0], req_frame_byte};
         end
         count_upd = byte_count_ff + 6'd1;
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      ether_type_in = ether_type_ff;
      dest_in       = dest_ff;
      cmd_valid     = 1'b0;
      cmd           = '0;
      if (accept) begin
         if (req_type == REQ_RULE) begin
            if (rule_ok) begin
               cmd_valid   = 1'b1;
               cmd.kind    = CMD_RULE;
               cmd.address = req_rule_address;
               cmd.index   = req_rule_index;
               cmd.valid   = req_rule_valid;
               cmd.plen    = req_rule_prefix_len;
               cmd.allow   = (req_rule_value == ALLOW_VALUE);
            end
         end else if (req_frame_last) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_VERDICT;
            if (count_upd < ETH_HDR_BYTES) begin
               cmd.cause = CAUSE_SHORT_ETH;
            end else if (ether_upd != ETHERTYPE_IPV4) begin
               cmd.cause = CAUSE_NOT_IPV4;
            end else if (count_upd < IP_END_BYTES) begin
               cmd.cause = CAUSE_SHORT_IP;
            end else begin
               cmd.kind    = CMD_SEARCH;
               cmd.address = dest_upd;
            end
            byte_count_in = '0;
            ether_type_in = '0;
            dest_in       = '0;
         end else begin
            byte_count_in = count_upd;
            ether_type_in = ether_upd;
            dest_in       = dest_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         ether_type_ff <= '0;
         dest_ff       <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         ether_type_ff <= ether_type_in;
         dest_ff       <= dest_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/iepf_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iepf_search
// rule table and longest prefix scan, one entry per cycle
// ----------------------------------------------------------------------------
module iepf_search
   import iepf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_empty,
   input  wire cmd_type cmd,
   output logic      cmd_pop,
   input  wire logic res_full,
   output logic      res_push,
   output result_type res,
   output logic      clearing
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   rule_entry_type rule_mem [TABLE_ENTRIES];

   bk_state_type    state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic            rd_vld_ff;
   rule_entry_type  entry_ff;
   logic [31:0]     dest_ff;
   logic            found_ff;
   logic [5:0]      best_len_ff;
   logic            best_allow_ff;

   logic            mem_we;
   logic [IDX_W-1:0] mem_waddr;
   rule_entry_type  mem_wdata;
   logic            start;
   logic            rd_en;
   logic            hit;
   logic [IDX_WIDE_W-1:0] idx_wide;

   assign idx_wide = IDX_WIDE_W'(cmd.index);
   assign hit = entry_ff.valid &&
                (((dest_ff ^ entry_ff.address) & prefix_mask(entry_ff.plen)) == 32'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!cmd_empty && cmd.kind == CMD_SEARCH) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (ptr_ff == LAST_IDX) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!res_full) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = '0;
      cmd_pop   = 1'b0;
      res_push  = 1'b0;
      res       = '0;
      start     = 1'b0;
      rd_en     = 1'b0;
      clearing  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            mem_we   = 1'b1;
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.kind)
                  CMD_RULE: begin
                     mem_we            = 1'b1;
                     mem_waddr         = idx_wide[IDX_W-1:0];
                     mem_wdata.valid   = cmd.valid;
                     mem_wdata.plen    = cmd.plen;
                     mem_wdata.address = cmd.address;
                     mem_wdata.allow   = cmd.allow;
                     cmd_pop           = 1'b1;
                  end
                  CMD_VERDICT: begin
                     if (!res_full) begin
                        res_push  = 1'b1;
                        res.cause = cmd.cause;
                        cmd_pop   = 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     start   = 1'b1;
                     cmd_pop = 1'b1;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
         end
         ST_EMIT: begin
            res_push = !res_full;
            res.dest = dest_ff;
            if (found_ff && best_allow_ff) begin
               res.cause = CAUSE_RULE_ALLOW;
            end else if ((dest_ff & LOOP_MASK) == LOOP_NET) begin
               res.cause = CAUSE_LOOPBACK;
            end else begin
               res.cause   = CAUSE_NO_ALLOW;
               res.verdict = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (clearing || rd_en) begin
         ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      end
      if (start) begin
         ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_en;
         if (start) begin
            found_ff <= 1'b0;
         end else if (rd_vld_ff && hit && (!found_ff || entry_ff.plen > best_len_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   // best match so far, strict compare keeps the lowest index on a tie
   always_ff @(posedge clock) begin
      if (start) begin
         dest_ff <= cmd.address;
      end
      if (rd_vld_ff && hit && (!found_ff || entry_ff.plen > best_len_ff)) begin
         best_len_ff   <= entry_ff.plen;
         best_allow_ff <= entry_ff.allow;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rule_mem[mem_waddr] <= mem_wdata;
      end
      entry_ff <= rule_mem[ptr_ff];
   end

endmodule
`default_nettype wire

### hw/rtl/ipv4_egress_prefix_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_egress_prefix_filter_core
// ipv4 egress filter with a longest prefix match rule table
// ----------------------------------------------------------------------------
// Items are frame bytes or rule writes, pushed through a queue-style port
// (req_push/req_full); verdicts come out of a second queue (rsp_empty/rsp_pop),
// one per frame, in frame order. The parser takes one item per cycle while
// req_full is low and classifies each frame at its last byte; frames too
// short, non-IPv4 or with a short IPv4 header get their verdict from the back
// end's idle state without a scan. A full IPv4 frame starts a scan of the rule
// table held in a memory, one entry per cycle, then a drain and an emit state;
// the parser keeps taking the following frame's bytes meanwhile, until the
// command queue (CMD_DEPTH entries) fills. Rule writes pass through the same
// queue, so a rule takes effect only for frames that end after it. After reset
// a clearing pass over every table entry invalidates every rule, and req_full
// stays high during it.
// ----------------------------------------------------------------------------
module ipv4_egress_prefix_filter_core
   import iepf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item input
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_frame_last,
   input  wire logic [9:0]  req_rule_index,
   input  wire logic        req_rule_valid,
   input  wire logic [5:0]  req_rule_prefix_len,
   input  wire logic [31:0] req_rule_address,
   input  wire logic [7:0]  req_rule_value,
   // verdict output
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_verdict,
   output logic [2:0]       rsp_cause,
   output logic [31:0]      rsp_dest_address
);

   logic       accept;
   logic       cmd_valid;
   cmd_type    cmd_in_data;
   cmd_type    cmd_out_data;
   logic       cmd_full;
   logic       cmd_empty;
   logic       cmd_pop;
   logic       clearing;
   logic       res_push;
   logic       res_full;
   result_type res_in_data;
   result_type res_out_data;

   // no items while the table is being cleared or the command queue is full
   assign req_full = cmd_full || clearing;
   assign accept   = req_push && !req_full;

   // front: header parse and classification
   iepf_parser #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_parser (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_type            (req_type),
      .req_frame_byte      (req_frame_byte),
      .req_frame_last      (req_frame_last),
      .req_rule_index      (req_rule_index),
      .req_rule_valid      (req_rule_valid),
      .req_rule_prefix_len (req_rule_prefix_len),
      .req_rule_address    (req_rule_address),
      .req_rule_value      (req_rule_value),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd_in_data)
   );

   // decoupling queue between parser and search engine
   iepf_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // back: rule table, prefix scan and verdict
   iepf_search #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_in_data),
      .clearing  (clearing)
   );

   // verdict queue, lets the scan finish while the consumer stalls
   iepf_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_verdict      = res_out_data.verdict;
   assign rsp_cause        = res_out_data.cause;
   assign rsp_dest_address = res_out_data.dest;

endmodule
`default_nettype wire

### bench/iepf_checker.sv
// ----------------------------------------------------------------------------
// iepf_checker
// watches both queue ports of the prefix filter, predicts and compares verdicts
// ----------------------------------------------------------------------------
// Keeps its own frame parser state and its own copy of the rule table. Every
// accepted rule write with index and length in range updates that copy. A
// frame's last byte queues the expected verdict, and each popped verdict is
// checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module iepf_checker
   import iepf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_frame_last,
   input  wire logic [9:0]  req_rule_index,
   input  wire logic        req_rule_valid,
   input  wire logic [5:0]  req_rule_prefix_len,
   input  wire logic [31:0] req_rule_address,
   input  wire logic [7:0]  req_rule_value,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic        rsp_verdict,
   input  wire logic [2:0]  rsp_cause,
   input  wire logic [31:0] rsp_dest_address,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // frame parse state
   logic [5:0]  frame_pos;
   logic [15:0] ether_word;
   logic [31:0] dest_word;

   // shadow rule table
   logic        rule_on   [TABLE_ENTRIES];
   logic [5:0]  rule_plen [TABLE_ENTRIES];
   logic [31:0] rule_addr [TABLE_ENTRIES];
   logic [7:0]  rule_val  [TABLE_ENTRIES];

   result_type verdicts_due[$];

   always @(posedge clock) begin : watch
      result_type  want;
      logic [31:0] mask;
      logic        hit;
      logic [5:0]  best_len;
      logic [7:0]  best_val;
      int          i;
      if (reset) begin
         frame_pos  = '0;
         ether_word = '0;
         dest_word  = '0;
         for (i = 0; i < TABLE_ENTRIES; i++) begin
            rule_on[i] = 1'b0;
         end
         verdicts_due.delete();
         fail_count = 0;
      end else begin
         // verdict side first: a result can never come from this edge's item
         if (rsp_pop && !rsp_empty) begin
            if (verdicts_due.size() == 0) begin
               fail_count++;
               $display("%0t: verdict with none expected: verdict %0b cause %0d dest %h",
                        $time, rsp_verdict, rsp_cause, rsp_dest_address);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  fail_count++;
                  $display("%0t: verdict mismatch: expected %0b, actual %0b",
                           $time, want.verdict, rsp_verdict);
               end
               if (rsp_cause !== want.cause) begin
                  fail_count++;
                  $display("%0t: cause mismatch: expected %0d, actual %0d",
                           $time, want.cause, rsp_cause);
               end
               if (rsp_dest_address !== want.dest) begin
                  fail_count++;
                  $display("%0t: dest mismatch: expected %h, actual %h",
                           $time, want.dest, rsp_dest_address);
               end
            end
         end

         if (req_push && !req_full) begin
            if (req_type == REQ_RULE) begin
               if (int'(req_rule_index) < TABLE_ENTRIES && req_rule_prefix_len <= MAX_PREFIX)
               begin
                  rule_on[req_rule_index]   = req_rule_valid;
                  rule_plen[req_rule_index] = req_rule_prefix_len;
                  rule_addr[req_rule_index] = req_rule_address;
                  rule_val[req_rule_index]  = req_rule_value;
               end
            end else begin
               if (frame_pos < IP_END_BYTES) begin
                  if (frame_pos == POS_ETYPE_HI || frame_pos == POS_ETYPE_LO) begin
                     ether_word = {ether_word[7:0], req_frame_byte};
                  end else if (frame_pos >= POS_DEST_FIRST) begin
                     dest_word = {dest_word[23:0], req_frame_byte};
                  end
                  frame_pos = frame_pos + 6'd1;
               end
               if (req_frame_last) begin
                  want.verdict = 1'b0;
                  want.dest    = '0;
                  if (frame_pos < ETH_HDR_BYTES) begin
                     want.cause = CAUSE_SHORT_ETH;
                  end else if (ether_word != ETHERTYPE_IPV4) begin
                     want.cause = CAUSE_NOT_IPV4;
                  end else if (frame_pos < IP_END_BYTES) begin
                     want.cause = CAUSE_SHORT_IP;
                  end else begin
                     want.dest = dest_word;
                     hit       = 1'b0;
                     best_len  = '0;
                     best_val  = '0;
                     // longest prefix, first index kept on a tie
                     for (i = 0; i < TABLE_ENTRIES; i++) begin
                        mask = ~(32'hFFFF_FFFF >> rule_plen[i]);
                        if (rule_on[i] && ((dest_word ^ rule_addr[i]) & mask) == 32'd0
                            && (!hit || rule_plen[i] > best_len)) begin
                           hit      = 1'b1;
                           best_len = rule_plen[i];
                           best_val = rule_val[i];
                        end
                     end
                     if (hit && best_val == ALLOW_VALUE) begin
                        want.cause = CAUSE_RULE_ALLOW;
                     end else if ((dest_word & LOOP_MASK) == LOOP_NET) begin
                        want.cause = CAUSE_LOOPBACK;
                     end else begin
                        want.cause   = CAUSE_NO_ALLOW;
                        want.verdict = 1'b1;
                     end
                  end
                  verdicts_due.push_back(want);
                  frame_pos  = '0;
                  ether_word = '0;
                  dest_word  = '0;
               end
            end
         end
      end
      pending = verdicts_due.size();
   end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the ipv4 egress prefix filter core
// ----------------------------------------------------------------------------
// Streams frames of every class (short ethernet, other ethertypes, short ipv4,
// full ipv4) and rule writes into the filter, with random gaps on the item
// side and random stalls on the verdict side. A checker beside the block
// predicts every verdict and counts mismatches; this module only drives items,
// pops verdicts and reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;
   import iepf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = 1024;
   // a full ipv4 verdict scans the whole table, so allow plenty per frame
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int ITEM_TARGET   = 950;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_type;
   logic [7:0]  req_frame_byte;
   logic        req_frame_last;
   logic [9:0]  req_rule_index;
   logic        req_rule_valid;
   logic [5:0]  req_rule_prefix_len;
   logic [31:0] req_rule_address;
   logic [7:0]  req_rule_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_verdict;
   logic [2:0]  rsp_cause;
   logic [31:0] rsp_dest_address;
   int          fail_count;
   int          pending;

   // stimulus bookkeeping
   bit          steady;         // no gaps and no stalls while set
   int          items_sent;     // items with an effect on the block
   int          cycle_count;
   logic [31:0] addr_pool [16]; // recent rule prefixes, reused as destinations

   ipv4_egress_prefix_filter_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (.*);

   iepf_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic bit idle_now();
      return !steady && ($urandom_range(0, 99) < 11);
   endfunction

   // verdict side: pop most cycles, stall at random
   always @(negedge clock) begin
      rsp_pop <= !idle_now();
   end

   // one item through the push port; entered and left at a falling edge
   task automatic push_item(input req_kind_type kind, input logic [7:0] data_byte,
                            input logic last, input logic [9:0] idx, input logic ok,
                            input logic [5:0] plen, input logic [31:0] addr,
                            input logic [7:0] val);
      while (idle_now()) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push            <= 1'b1;
      req_type            <= kind;
      req_frame_byte      <= data_byte;
      req_frame_last      <= last;
      req_rule_index      <= idx;
      req_rule_valid      <= ok;
      req_rule_prefix_len <= plen;
      req_rule_address    <= addr;
      req_rule_value      <= val;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      if (kind == REQ_FRAME || plen <= MAX_PREFIX) items_sent++;
   endtask

   // rule write; frame fields carry noise
   task automatic load_rule(input logic [9:0] idx, input logic ok, input logic [5:0] plen,
                            input logic [31:0] addr, input logic [7:0] val);
      push_item(REQ_RULE, 8'($urandom), 1'($urandom), idx, ok, plen, addr, val);
   endtask

   // random destination: near a known prefix, in 127/8, or anywhere
   function automatic logic [31:0] pick_dest();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return addr_pool[$urandom_range(0, 15)]
                ^ (32'($urandom) & (32'hFFFF_FFFF >> $urandom_range(8, 32)));
      end else if (roll < 70) begin
         return {8'h7F, 24'($urandom)};
      end
      return 32'($urandom);
   endfunction

   task automatic random_rule();
      logic [9:0]  idx;
      logic [5:0]  plen;
      logic [31:0] addr;
      logic [7:0]  val;
      // a small index range keeps overwrites and ties frequent
      idx  = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, 31)) : 10'($urandom);
      // some lengths past 32 so that the write is dropped
      plen = ($urandom_range(0, 99) < 92) ? 6'($urandom_range(0, 32))
                                           : 6'($urandom_range(33, 63));
      addr = ($urandom_range(0, 99) < 50) ? pick_dest() : 32'($urandom);
      val  = ($urandom_range(0, 99) < 50) ? ALLOW_VALUE : 8'($urandom);
      addr_pool[$urandom_range(0, 15)] = addr;
      load_rule(idx, $urandom_range(0, 99) < 85, plen, addr, val);
   endtask

   // whole frame, ethertype and destination placed at their byte positions;
   // rule_odds is the percent chance of a rule write ahead of each byte
   task automatic send_frame(input int nbytes, input logic [15:0] etype,
                             input logic [31:0] dst, input int rule_odds);
      logic [7:0] data_byte;
      int         pos;
      for (pos = 0; pos < nbytes; pos++) begin
         if ($urandom_range(0, 99) < rule_odds) random_rule();
         if (pos == POS_ETYPE_HI) data_byte = etype[15:8];
         else if (pos == POS_ETYPE_LO) data_byte = etype[7:0];
         else if (pos >= POS_DEST_FIRST && pos < IP_END_BYTES)
            data_byte = dst[8 * (IP_END_BYTES - 1 - pos) +: 8];
         else data_byte = 8'($urandom);
         push_item(REQ_FRAME, data_byte, pos == nbytes - 1, 10'($urandom), 1'($urandom),
                   6'($urandom), 32'($urandom), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [15:0] etype;
      int          roll;
      int          pick;
      bit          paused;

      reset               = 1'b1;
      req_push            = 1'b0;
      req_type            = REQ_FRAME;
      req_frame_byte      = '0;
      req_frame_last      = 1'b0;
      req_rule_index      = '0;
      req_rule_valid      = 1'b0;
      req_rule_prefix_len = '0;
      req_rule_address    = '0;
      req_rule_value      = '0;
      rsp_pop             = 1'b0;
      cycle_count         = 0;
      items_sent          = 0;
      steady              = 1'b0;
      paused              = 1'b0;
      for (int i = 0; i < 16; i++) addr_pool[i] = 32'($urandom);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, table empty to begin with ----
      send_frame(1, ETHERTYPE_IPV4, 32'h0, 0);            // single byte frame
      send_frame(13, ETHERTYPE_IPV4, 32'h0, 0);           // one short of eth header
      send_frame(14, 16'h86DD, 32'h0, 0);                 // ipv6, not ipv4
      send_frame(33, ETHERTYPE_IPV4, 32'h0A01_0203, 0);   // one short of the dest
      send_frame(34, ETHERTYPE_IPV4, 32'h0A01_0203, 0);   // no rule, dropped
      send_frame(34, ETHERTYPE_IPV4, 32'h7F00_0001, 0);   // loopback
      // prefix past 32 and the largest length code: both writes dropped
      load_rule(10'd0, 1'b1, 6'd33, 32'h0, ALLOW_VALUE);
      load_rule(10'd7, 1'b1, 6'd63, 32'hFFFF_FFFF, 8'hFF);
      send_frame(34, ETHERTYPE_IPV4, 32'h0000_0000, 0);
      // exact host rule in the top slot
      load_rule(10'd1023, 1'b1, MAX_PREFIX, 32'hFFFF_FFFF, ALLOW_VALUE);
      send_frame(34, ETHERTYPE_IPV4, 32'hFFFF_FFFF, 0);
      // zero length matches anything, its address bits never compared
      load_rule(10'd5, 1'b1, 6'd0, 32'hDEAD_BEEF, ALLOW_VALUE);
      send_frame(60, ETHERTYPE_IPV4, 32'h0A01_0203, 0);   // long frame, tail ignored
      // longer rule that does not allow hides the default allow
      load_rule(10'd3, 1'b1, 6'd8, 32'h0AFF_FFFF, 8'd0);
      send_frame(34, ETHERTYPE_IPV4, 32'h0A01_0203, 0);
      // same shadowing inside 127/8 falls back to loopback
      load_rule(10'd4, 1'b1, 6'd16, 32'h7F00_0000, 8'hFF);
      send_frame(34, ETHERTYPE_IPV4, 32'h7F00_0909, 0);
      // equal length at a lower slot wins the tie
      load_rule(10'd2, 1'b1, 6'd8, 32'h0A00_0000, ALLOW_VALUE);
      send_frame(34, ETHERTYPE_IPV4, 32'h0A01_0203, 0);
      // removal brings the drop back
      load_rule(10'd2, 1'b0, 6'd8, 32'h0A00_0000, ALLOW_VALUE);
      send_frame(34, ETHERTYPE_IPV4, 32'h0A01_0203, 0);
      // rule writes in the middle of a frame
      send_frame(36, ETHERTYPE_IPV4, 32'h0A00_0001, 15);

      // ---- random part ----
      while (items_sent < ITEM_TARGET) begin
         // a stretch with neither gaps nor stalls
         steady = (items_sent >= 500 && items_sent < 700);
         // hold items back until every verdict is out
         if (items_sent >= 800 && !paused) begin
            paused = 1'b1;
            req_push <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) random_rule();
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_frame($urandom_range(1, 13), 16'($urandom), pick_dest(), 2);
         end else if (roll < 16) begin
            pick  = $urandom_range(0, 99);
            etype = (pick < 30) ? (ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15)))
                                : 16'($urandom);
            if (etype == ETHERTYPE_IPV4) etype = 16'h0806;
            send_frame($urandom_range(14, 40), etype, pick_dest(), 2);
         end else if (roll < 24) begin
            send_frame($urandom_range(14, 33), ETHERTYPE_IPV4, pick_dest(), 2);
         end else begin
            pick = ($urandom_range(0, 99) < 85) ? $urandom_range(34, 40)
                                                : $urandom_range(41, 63);
            send_frame(pick, ETHERTYPE_IPV4, pick_dest(), 2);
         end
      end

      // ---- drain ----
      steady = 1'b0;
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      // room for a late extra verdict to show up
      repeat (TABLE_ENTRIES + 50) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### ipv4_egress_prefix_filter_core.f
hw/rtl/iepf_pkg.sv
hw/rtl/iepf_fifo.sv
hw/rtl/iepf_parser.sv
hw/rtl/iepf_search.sv
hw/rtl/ipv4_egress_prefix_filter_core.sv
bench/iepf_checker.sv
bench/tb_top.sv
